>>> src/floyd_steinberg_rgb565_dither_assert.svh
// Assertion macros shared by the dither RTL.
// Each macro takes a label, the clock, the active-low reset and a message.
`ifndef FLOYD_STEINBERG_RGB565_DITHER_ASSERT_SVH
`define FLOYD_STEINBERG_RGB565_DITHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// The condition must never be true.
`define FSD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

`endif

>>> src/fsd_pkg.sv
`default_nettype none

package fsd_pkg;

    // Default depth of the next-row error line.
    localparam int FSD_MAX_WIDTH_DEF = 1024;

    // Width of the image width register and its reset value.
    localparam int          CFG_W       = 11;
    localparam logic [10:0] WIDTH_RESET = 11'd256;

    // Diffused errors stay within a few tens, so eight signed bits suffice.
    localparam int ERR_W  = 8;
    localparam int N_CHAN = 3;

    typedef logic signed [ERR_W-1:0] t_err;

    // One error per channel: index 0 red, 1 green, 2 blue.
    typedef logic [N_CHAN-1:0][ERR_W-1:0] t_err3;

    // Position flags of a request, worked out when it is taken.
    typedef struct packed {
        logic restart;    // first pixel of an image: row state starts from zero
        logic last;       // last pixel of its row
        logic first_row;  // no row above, the line buffer reads as zero
    } t_pos;

    // Rounded quantization: (v*63+127)/255 for six bits, (v*31+127)/255 for five.
    // The divide by 255 is (x + (x >> 8) + 1) >> 8, exact over this range.
    function automatic logic [5:0] quant(input logic [7:0] v, input logic six_bit);
        logic [13:0] x;
        logic [13:0] t;
        x = six_bit ? (({6'd0, v} << 6) - {6'd0, v} + 14'd127)
                    : (({6'd0, v} << 5) - {6'd0, v} + 14'd127);
        t = x + 14'd1 + {8'd0, x[13:8]};
        return t[13:8];
    endfunction

    // Expand a code back to eight bits by repeating its top bits.
    function automatic logic [7:0] expand(input logic [5:0] q, input logic six_bit);
        logic [7:0] r;
        if (six_bit) begin
            r = {q[5:0], q[5:4]};
        end else begin
            r = {q[4:0], q[4:2]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/fsd_line_mem.sv
`default_nettype none

// Next-row error line: one write port, one read port with registered data.
module fsd_line_mem import fsd_pkg::*; #(
    parameter int  MAX_WIDTH = FSD_MAX_WIDTH_DEF,
    localparam int AW        = $clog2(MAX_WIDTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_err3         i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_err3              o_rdata
);

    t_err3 mem [MAX_WIDTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/fsd_col_track.sv
`default_nettype none

// Column and first-row tracking on the input side, so the line buffer
// read address is known at the edge that takes a request.
module fsd_col_track import fsd_pkg::*; #(
    parameter int  MAX_WIDTH = FSD_MAX_WIDTH_DEF,
    localparam int AW        = $clog2(MAX_WIDTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_first_of_image,
    input  wire logic [CFG_W-1:0] i_width,
    output logic [AW-1:0]         o_col,
    output t_pos                  o_pos
);

    localparam int CW = (AW + 1 > CFG_W + 1) ? AW + 1 : CFG_W + 1;

    logic [AW-1:0] r_col;
    logic [AW-1:0] n_col;
    logic          r_first_row;
    logic          n_first_row;
    logic [CW-1:0] w_width;
    logic [CW-1:0] w_width_eff;
    logic [CW-1:0] w_col_ext;

    // Width zero acts as one, and a width past the line depth as the depth.
    assign w_width = CW'(i_width);
    always_comb begin
        if (w_width == '0) begin
            w_width_eff = CW'(1);
        end else if (w_width > CW'(MAX_WIDTH)) begin
            w_width_eff = CW'(MAX_WIDTH);
        end else begin
            w_width_eff = w_width;
        end
    end

    // Position of the request at the input.
    assign o_col           = i_first_of_image ? '0 : r_col;
    assign w_col_ext       = CW'(o_col);
    assign o_pos.restart   = i_first_of_image;
    assign o_pos.first_row = i_first_of_image | r_first_row;
    assign o_pos.last      = (w_col_ext + CW'(1)) >= w_width_eff;

    // Advance the column, or start the next row.
    always_comb begin
        n_col       = r_col;
        n_first_row = r_first_row;
        if (i_accept) begin
            if (o_pos.last) begin
                n_col       = '0;
                n_first_row = 1'b0;
            end else begin
                n_col       = o_col + AW'(1);
                n_first_row = o_pos.first_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
        end else begin
            r_col       <= n_col;
            r_first_row <= n_first_row;
        end
    end

endmodule

`default_nettype wire

>>> src/fsd_chan.sv
`default_nettype none

// One color channel: add the diffused error, clamp, quantize, and split
// the new error into its right, down-left, down and down-right parts.
module fsd_chan import fsd_pkg::*; (
    input  wire logic [7:0] i_pix,
    input  wire logic       i_six_bit,
    input  wire t_err       i_carry,
    input  wire t_err       i_line,
    input  wire logic       i_use_line,
    input  wire t_err       i_pdl,
    input  wire t_err       i_pd,
    output logic [5:0]      o_code,
    output t_err            o_err,
    output t_err            o_down_write,
    output t_err            o_pdl_next,
    output t_err            o_carry_next
);

    logic signed [9:0] w_acc;
    logic signed [9:0] w_rnd;
    logic signed [9:0] w_sum;
    logic        [7:0] w_val;
    logic        [7:0] w_back;
    logic signed [9:0] w_diff;

    // Errors are held scaled by 16; round them back as floor((acc + 8) / 16).
    assign w_acc = 10'(i_carry) + (i_use_line ? 10'(i_line) : 10'sd0);
    assign w_rnd = (w_acc + 10'sd8) >>> 4;
    assign w_sum = $signed({2'b00, i_pix}) + w_rnd;

    // Clamp to the 8-bit range.
    always_comb begin
        if (w_sum < 10'sd0) begin
            w_val = 8'd0;
        end else if (w_sum > 10'sd255) begin
            w_val = 8'd255;
        end else begin
            w_val = w_sum[7:0];
        end
    end

    // Quantize and measure what the code loses.
    assign o_code = quant(w_val, i_six_bit);
    assign w_back = expand(o_code, i_six_bit);
    assign w_diff = $signed({2'b00, w_val}) - $signed({2'b00, w_back});
    assign o_err  = w_diff[ERR_W-1:0];

    // Spread the error: 3/16 down-left, 5/16 down, 1/16 down-right, 7/16 right.
    assign o_down_write = ERR_W'(i_pdl + 3 * o_err);
    assign o_pdl_next   = ERR_W'(i_pd + 5 * o_err);
    assign o_carry_next = ERR_W'(7 * o_err);

endmodule

`default_nettype wire

>>> src/floyd_steinberg_rgb565_dither.sv
// Floyd-Steinberg dither of an RGB888 raster stream to RGB565.
// Input channel: i_valid / o_ready with i_red, i_green, i_blue and
// i_first_of_image, which marks the first pixel of a new image.
// Output channel: o_valid / i_ready with o_pixel_565 and o_row_end, one
// result per request, in request order.
// Configuration: i_cfg_valid / o_cfg_ready carry i_image_width, the number
// of pixels per row; o_cfg_ready is always high. Write it only while idle.
// A taken request is registered into the execute stage, executed there, and
// its result registered in the output register once that register is free.
// Throughput: one pixel per clock while the receiver takes results. The line
// buffer is read when a request is taken and written when it executes; the
// right-carry error loop closes within the execute stage.
// When the receiver stalls, the result waits in the output register and one
// more request is taken into the execute stage; after that o_ready falls.
// Reset clears the row state and starts a new image at column zero, width 256.
// The line buffer is not cleared: the first row of each image reads zero
// error. The user, not the block, must see each entry written before it is read.
`default_nettype none

module floyd_steinberg_rgb565_dither import fsd_pkg::*; #(
    parameter int MAX_WIDTH = FSD_MAX_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_image_width,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [7:0]       i_red,
    input  wire logic [7:0]       i_green,
    input  wire logic [7:0]       i_blue,
    input  wire logic             i_first_of_image,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [15:0]           o_pixel_565,
    output logic                  o_row_end
);

`include "floyd_steinberg_rgb565_dither_assert.svh"

    localparam int AW = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0] r_width;

    // Input side.
    logic                   w_accept;
    logic [AW-1:0]          w_col;
    t_pos                   w_pos;
    logic [N_CHAN-1:0][7:0] w_pix;

    // Execute stage.
    logic                   r_s1_valid;
    logic [N_CHAN-1:0][7:0] r_s1_pix;
    logic [AW-1:0]          r_s1_col;
    t_pos                   r_s1_pos;
    logic                   w_exec;

    // Row state.
    t_err3 r_carry;
    t_err3 r_pdl;
    t_err3 r_pd;

    // Line buffer access and forwarding.
    t_err3         w_rdata;
    t_err3         w_line;
    logic          r_fwd_hit;
    t_err3         r_fwd_data;
    logic          n_fwd_hit;
    t_err3         n_fwd_data;
    logic          w_direct_we;
    logic [AW-1:0] w_direct_addr;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    t_err3         w_mem_wdata;

    // Down entry for the last column, written in the following cycle.
    logic          r_tail_valid;
    logic [AW-1:0] r_tail_addr;
    t_err3         r_tail_data;

    // Channel results.
    logic [N_CHAN-1:0][5:0] w_code;
    t_err3                  w_err;
    t_err3                  w_down;
    t_err3                  w_pdl_next;
    t_err3                  w_carry_next;
    t_err3                  w_carry_eff;
    t_err3                  w_pdl_eff;
    t_err3                  w_pd_eff;

    // Output register.
    logic        r_out_valid;
    logic [15:0] r_out_pixel;
    logic        r_out_row_end;

    // Configuration register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_image_width;
        end
    end

    // Handshakes: execute moves when the output register can take a result.
    assign w_exec   = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_s1_valid || w_exec;
    assign w_accept = i_valid && o_ready;

    assign w_pix = {i_blue, i_green, i_red};

    fsd_col_track #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_col_track (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_first_of_image (i_first_of_image),
        .i_width          (r_width),
        .o_col            (w_col),
        .o_pos            (w_pos)
    );

    // Line buffer write port: the down-left write of the executing pixel,
    // otherwise the pending last-column entry.
    assign w_direct_we   = w_exec && (r_s1_col != '0);
    assign w_direct_addr = r_s1_col - AW'(1);
    assign w_mem_we      = w_direct_we || r_tail_valid;
    assign w_mem_waddr   = w_direct_we ? w_direct_addr : r_tail_addr;
    assign w_mem_wdata   = w_direct_we ? w_down : r_tail_data;

    fsd_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_accept),
        .i_raddr (w_col),
        .o_rdata (w_rdata)
    );

    // Writes at the read edge are not seen by the read; capture them here.
    // The newest write to the same entry wins.
    always_comb begin
        n_fwd_hit  = 1'b0;
        n_fwd_data = r_tail_data;
        if (w_direct_we && (w_direct_addr == w_col)) begin
            n_fwd_hit  = 1'b1;
            n_fwd_data = w_down;
        end else if (w_exec && r_s1_pos.last && (r_s1_col == w_col)) begin
            n_fwd_hit  = 1'b1;
            n_fwd_data = w_pdl_next;
        end else if (r_tail_valid && (r_tail_addr == w_col)) begin
            n_fwd_hit  = 1'b1;
            n_fwd_data = r_tail_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fwd_hit  <= n_fwd_hit;
            r_fwd_data <= n_fwd_data;
            r_s1_pix   <= w_pix;
            r_s1_col   <= w_col;
            r_s1_pos   <= w_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_exec) begin
            r_s1_valid <= 1'b0;
        end
    end

    assign w_line = r_fwd_hit ? r_fwd_data : w_rdata;

    // A new image starts with no carried or pending error.
    assign w_carry_eff = r_s1_pos.restart ? '0 : r_carry;
    assign w_pdl_eff   = r_s1_pos.restart ? '0 : r_pdl;
    assign w_pd_eff    = r_s1_pos.restart ? '0 : r_pd;

    for (genvar c = 0; c < N_CHAN; c++) begin : g_chan
        fsd_chan u_chan (
            .i_pix        (r_s1_pix[c]),
            .i_six_bit    (c == 1),
            .i_carry      (w_carry_eff[c]),
            .i_line       (w_line[c]),
            .i_use_line   (!r_s1_pos.first_row),
            .i_pdl        (w_pdl_eff[c]),
            .i_pd         (w_pd_eff[c]),
            .o_code       (w_code[c]),
            .o_err        (w_err[c]),
            .o_down_write (w_down[c]),
            .o_pdl_next   (w_pdl_next[c]),
            .o_carry_next (w_carry_next[c])
        );
    end

    // Row state moves with each executed pixel and clears at row end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
            r_pdl   <= '0;
            r_pd    <= '0;
        end else if (w_exec) begin
            if (r_s1_pos.last) begin
                r_carry <= '0;
                r_pdl   <= '0;
                r_pd    <= '0;
            end else begin
                r_carry <= w_carry_next;
                r_pdl   <= w_pdl_next;
                r_pd    <= w_err;
            end
        end
    end

    // The last column's down entry is registered and written in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_valid <= 1'b0;
        end else if (w_exec && r_s1_pos.last) begin
            r_tail_valid <= 1'b1;
        end else if (!w_direct_we) begin
            r_tail_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && r_s1_pos.last) begin
            r_tail_addr <= r_s1_col;
            r_tail_data <= w_pdl_next;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_pixel   <= {w_code[0][4:0], w_code[1][5:0], w_code[2][4:0]};
            r_out_row_end <= r_s1_pos.last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_565 = r_out_pixel;
    assign o_row_end   = r_out_row_end;

    // The pending last-column entry never competes with a down-left write.
    `FSD_ASSERT_NEVER(a_tail_port, i_clk, i_rst_n, r_tail_valid && w_direct_we, "tail write collides with down-left write")

    // The pending last-column entry is written in the very next cycle.
    `FSD_ASSERT_NEXT(a_tail_drain, i_clk, i_rst_n, r_tail_valid && !(w_exec && r_s1_pos.last), !r_tail_valid, "tail entry not drained")

    // After a row ends, the next pixel in the execute stage is at column zero.
    `FSD_ASSERT_NEXT(a_row_restart, i_clk, i_rst_n, w_exec && r_s1_pos.last, !r_s1_valid || (r_s1_col == '0), "column tracking out of step after row end")

    // A request is never taken on top of a pixel that cannot leave.
    `FSD_ASSERT_IMPL(a_no_overrun, i_clk, i_rst_n, w_accept && r_s1_valid, w_exec, "execute stage overwritten")

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int CFG_W       = fsd_pkg::CFG_W;
    localparam int MAX_W       = fsd_pkg::FSD_MAX_WIDTH_DEF;
    localparam int CH_R        = 0;
    localparam int CH_G        = 1;
    localparam int CH_B        = 2;
    localparam int HOLD_CYCLES = 400;
    localparam int PRESS_ITEMS = 40;
    localparam int RAND_ITEMS  = 780;
    localparam int CYCLE_LIMIT = 600000;
    localparam int N_DIRECTED  = 20;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       new_image;
    } t_pix_req;

    typedef struct packed {
        logic [15:0] pix;
        logic        row_end;
    } t_pix_res;

    // One row of the directed table; cfg below zero means no width write first.
    typedef struct {
        int       cfg;
        t_pix_req rq;
        bit       typed;
        t_pix_res res;
    } t_step;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_image_width;
    logic             i_valid;
    logic             o_ready;
    logic [7:0]       i_red;
    logic [7:0]       i_green;
    logic [7:0]       i_blue;
    logic             i_first_of_image;
    logic             o_valid;
    logic             i_ready;
    logic [15:0]      o_pixel_565;
    logic             o_row_end;

    floyd_steinberg_rgb565_dither dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_image_width    (i_image_width),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_first_of_image (i_first_of_image),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pixel_565      (o_pixel_565),
        .o_row_end        (o_row_end)
    );

    // Dither state kept by the bench, scaled by 16 like the block's own errors.
    logic [CFG_W-1:0] width_reg = fsd_pkg::WIDTH_RESET;
    shortint          err_line [MAX_W][3];
    bit               written [MAX_W];
    int               carry [3];
    int               pend_dl [3];
    int               pend_d [3];
    int unsigned      col_cnt = 0;
    bit               first_row = 1'b1;

    t_pix_res expected_px [$];
    int       fails = 0;
    int       px_sent = 0;
    int       cycle_cnt = 0;
    bit       tx_idle_on = 1'b0;
    bit       rx_idle_on = 1'b0;
    bit       hold_off_req = 1'b0;

    // Directed requests: color extremes, width limits, a width shrunk in mid-row,
    // restarts, and values whose error is negative.
    t_step dir_steps [N_DIRECTED] = '{
        '{-1,   '{8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{16'h0000, 1'b0}},
        '{-1,   '{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1, '{16'hFFFF, 1'b0}},
        '{-1,   '{8'd128, 8'd64,  8'd200, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{-1,   '{8'd5,   8'd250, 8'd4,   1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{-1,   '{8'd131, 8'd2,   8'd253, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{1,    '{8'd100, 8'd101, 8'd102, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{-1,   '{8'd30,  8'd200, 8'd90,  1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{-1,   '{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, '{16'h0000, 1'b1}},
        '{0,    '{8'd77,  8'd33,  8'd11,  1'b1}, 1'b0, '{16'h0000, 1'b0}},
        '{-1,   '{8'd200, 8'd10,  8'd240, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{3,    '{8'd12,  8'd34,  8'd56,  1'b1}, 1'b0, '{16'h0000, 1'b0}},
        '{-1,   '{8'd250, 8'd3,   8'd129, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{-1,   '{8'd6,   8'd6,   8'd6,   1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{-1,   '{8'd255, 8'd0,   8'd255, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{-1,   '{8'd0,   8'd255, 8'd0,   1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{-1,   '{8'd127, 8'd128, 8'd129, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{2047, '{8'd90,  8'd91,  8'd92,  1'b1}, 1'b0, '{16'h0000, 1'b0}},
        '{-1,   '{8'd1,   8'd254, 8'd7,   1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{-1,   '{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{-1,   '{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '{16'h0000, 1'b0}}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("floyd_steinberg_rgb565_dither test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        fails++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void clear_row();
        for (int c = 0; c < 3; c++) begin
            carry[c] = 0;
            pend_dl[c] = 0;
            pend_d[c] = 0;
        end
    endfunction

    // Dither one pixel: add diffused error, clamp, quantize, spread the error.
    function automatic void dither_pixel(input t_pix_req rq, output t_pix_res res);
        int unsigned w;
        int unsigned col;
        bit last;
        int chan [3];
        int q [3];
        int acc;
        int v;
        int e;
        int back;
        int levels;
        chan[CH_R] = int'(rq.red);
        chan[CH_G] = int'(rq.green);
        chan[CH_B] = int'(rq.blue);
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        if (rq.new_image) begin
            col_cnt = 0;
            first_row = 1'b1;
            clear_row();
        end
        col = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
        last = (col + 1 >= w);
        for (int c = 0; c < 3; c++) begin
            acc = carry[c];
            if (!first_row) acc += err_line[col][c];
            v = chan[c] + ((acc + 8) >>> 4);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            levels = (c == CH_G) ? 63 : 31;
            q[c] = (v * levels + 127) / 255;
            back = (c == CH_G) ? ((q[c] << 2) | (q[c] >> 4)) : ((q[c] << 3) | (q[c] >> 2));
            e = v - back;
            if (col >= 1) begin
                err_line[col-1][c] = shortint'(pend_dl[c] + 3 * e);
                written[col-1] = 1'b1;
            end
            pend_dl[c] = pend_d[c] + 5 * e;
            pend_d[c] = e;
            carry[c] = 7 * e;
            if (last) begin
                err_line[col][c] = shortint'(pend_dl[c]);
                written[col] = 1'b1;
            end
        end
        if (last) begin
            clear_row();
            col_cnt = 0;
            first_row = 1'b0;
        end else begin
            col_cnt = col + 1;
        end
        res.pix = {5'(q[CH_R]), 6'(q[CH_G]), 5'(q[CH_B])};
        res.row_end = last;
    endfunction

    function automatic t_pix_req rand_pixel();
        t_pix_req rq;
        case ($urandom_range(0, 7))
            0: begin
                rq.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                rq.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                rq.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            1: begin
                rq.red   = 8'($urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(249, 255));
                rq.green = 8'($urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(249, 255));
                rq.blue  = 8'($urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(249, 255));
            end
            default: begin
                rq.red   = 8'($urandom_range(0, 255));
                rq.green = 8'($urandom_range(0, 255));
                rq.blue  = 8'($urandom_range(0, 255));
            end
        endcase
        rq.new_image = 1'b0;
        return rq;
    endfunction

    // Offer one request and hold it until taken. A request that would read a
    // line buffer entry never written is turned into the start of a new image.
    task automatic send_pixel(input t_pix_req rq, input bit typed, input t_pix_res typed_res);
        t_pix_res res;
        int unsigned col;
        col = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
        if (!rq.new_image && !first_row && !written[col]) rq.new_image = 1'b1;
        dither_pixel(rq, res);
        expected_px.push_back(typed ? typed_res : res);
        i_valid          <= 1'b1;
        i_red            <= rq.red;
        i_green          <= rq.green;
        i_blue           <= rq.blue;
        i_first_of_image <= rq.new_image;
        do @(posedge i_clk); while (!o_ready);
        px_sent++;
    endtask

    task automatic tx_gap();
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
    endtask

    // Width writes happen only once every result has drained.
    task automatic write_width(input logic [CFG_W-1:0] w);
        i_valid <= 1'b0;
        while (expected_px.size() != 0) @(posedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_image_width <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        width_reg = w;
    endtask

    // Receiver: random stalls, plus one long hold-off when requested.
    initial begin : rx_side
        int stall;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                stall = gap_len();
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_pix_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_px.size() == 0) begin
                report_mismatch($sformatf("unexpected result pixel %h", o_pixel_565));
            end else begin
                want = expected_px.pop_front();
                if (o_pixel_565 !== want.pix) begin
                    report_mismatch($sformatf("pixel_565 got %h want %h", o_pixel_565, want.pix));
                end
                if (o_row_end !== want.row_end) begin
                    report_mismatch($sformatf("row_end got %b want %b", o_row_end, want.row_end));
                end
            end
        end
    end

    initial begin : stimulus
        t_pix_req rq;
        int w;
        int eff;
        int n;
        bit restart_img;
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_image_width    = '0;
        i_valid          = 1'b0;
        i_red            = '0;
        i_green          = '0;
        i_blue           = '0;
        i_first_of_image = 1'b0;
        clear_row();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, run with idling on both sides.
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (dir_steps[i]) begin
            if (dir_steps[i].cfg >= 0) write_width(dir_steps[i].cfg[CFG_W-1:0]);
            send_pixel(dir_steps[i].rq, dir_steps[i].typed, dir_steps[i].res);
            tx_gap();
        end

        // A burst at the widest setting, sender never pausing while the
        // receiver holds off long enough to fill the block.
        write_width(11'd2047);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        hold_off_req = 1'b1;
        for (int k = 0; k < PRESS_ITEMS; k++) begin
            rq = rand_pixel();
            rq.new_image = (k == 0);
            send_pixel(rq, 1'b0, '0);
        end

        // Random images, mostly small widths, a few at the limits.
        n = px_sent;
        while (px_sent - n < RAND_ITEMS) begin : rand_phase
            int cnt;
            case ($urandom_range(0, 19))
                0:       w = 0;
                1:       w = MAX_W;
                2:       w = $urandom_range(MAX_W + 1, 2047);
                3:       w = 1;
                default: w = $urandom_range(2, 24);
            endcase
            write_width(w[CFG_W-1:0]);
            eff = (w < 1) ? 1 : ((w > MAX_W) ? MAX_W : w);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (eff > 64) begin
                cnt = $urandom_range(20, 60);
            end else begin
                cnt = $urandom_range(1, 5) * eff;
                if ($urandom_range(0, 2) == 0) cnt += $urandom_range(0, eff - 1);
            end
            restart_img = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < cnt; k++) begin
                rq = rand_pixel();
                rq.new_image = (k == 0 && restart_img) || ($urandom_range(0, 39) == 0);
                send_pixel(rq, 1'b0, '0);
                tx_gap();
            end
        end

        // Drain and let the pipeline settle.
        i_valid <= 1'b0;
        while (expected_px.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fails == 0) begin
            $display("floyd_steinberg_rgb565_dither test passed");
        end else begin
            $display("floyd_steinberg_rgb565_dither test failed");
        end
        $finish;
    end

endmodule
